/* src/cdf_pkg.sv */
// Shared types, header codes and CRC helper for the CRC-8 header frame deframer.
`default_nettype none
package cdf_pkg;

  localparam int unsigned STORE_DEPTH = 9;
  localparam logic [7:0]  CRC_POLY    = 8'h07;

  localparam logic [2:0] KIND_START      = 3'd0;
  localparam logic [2:0] KIND_END        = 3'd1;
  localparam logic [2:0] KIND_VALUE      = 3'd2;
  localparam logic [2:0] KIND_CARD       = 3'd3;
  localparam logic [2:0] KIND_POWER_OFF  = 3'd4;
  localparam logic [2:0] KIND_POWER_ON   = 3'd5;
  localparam logic [2:0] KIND_ACK_DEAD   = 3'd6;
  localparam logic [2:0] KIND_ACK_REVIVE = 3'd7;

  localparam logic [15:0] HDR_START      = 16'hC11C;
  localparam logic [15:0] HDR_END        = 16'hC22C;
  localparam logic [15:0] HDR_VALUE      = 16'hC33C;
  localparam logic [15:0] HDR_CARD       = 16'hC44C;
  localparam logic [15:0] HDR_POWER_OFF  = 16'hC55C;
  localparam logic [15:0] HDR_POWER_ON   = 16'hC66C;
  localparam logic [15:0] HDR_ACK_DEAD   = 16'hE33E;
  localparam logic [15:0] HDR_ACK_REVIVE = 16'hE44E;

  localparam logic [3:0] LEN_ACK   = 4'd4;
  localparam logic [3:0] LEN_CMD   = 4'd7;
  localparam logic [3:0] LEN_VALUE = 4'd9;

  typedef logic [7:0] byte_t;

  typedef struct packed {
    logic       known;
    logic [2:0] kind;
    logic [3:0] len;
  } hdr_t;

  typedef struct packed {
    logic [2:0]  frame_kind;
    logic [3:0]  frame_length;
    logic [31:0] word_at_two;
    logic [15:0] word_at_six;
  } result_t;

  function automatic byte_t crc8_step(input byte_t val);
    byte_t c;
    c = val;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  function automatic hdr_t header_lookup(input byte_t h0, input byte_t h1);
    hdr_t h;
    h = '{known: 1'b1, kind: KIND_START, len: LEN_CMD};
    unique case ({h0, h1})
      HDR_START:      h = '{known: 1'b1, kind: KIND_START,      len: LEN_CMD};
      HDR_END:        h = '{known: 1'b1, kind: KIND_END,        len: LEN_CMD};
      HDR_VALUE:      h = '{known: 1'b1, kind: KIND_VALUE,      len: LEN_VALUE};
      HDR_CARD:       h = '{known: 1'b1, kind: KIND_CARD,       len: LEN_CMD};
      HDR_POWER_OFF:  h = '{known: 1'b1, kind: KIND_POWER_OFF,  len: LEN_CMD};
      HDR_POWER_ON:   h = '{known: 1'b1, kind: KIND_POWER_ON,   len: LEN_CMD};
      HDR_ACK_DEAD:   h = '{known: 1'b1, kind: KIND_ACK_DEAD,   len: LEN_ACK};
      HDR_ACK_REVIVE: h = '{known: 1'b1, kind: KIND_ACK_REVIVE, len: LEN_ACK};
      default:        h = '{known: 1'b0, kind: KIND_START,      len: 4'd0};
    endcase
    return h;
  endfunction

endpackage
`default_nettype wire

/* src/crc8_header_frame_deframer.sv */
// Top level of the CRC-8 header frame deframer: byte stream in, checked frames out.
// Takes one byte per clock while in_tready is high and keeps a running CRC-8
// (poly 0x07, init 0), so a frame is checked as its last byte arrives and its
// result is registered in the output buffer behind out_tvalid; unknown header pairs
// and frames with a bad CRC give no result. A two-entry output buffer lets
// bytes keep flowing while a result waits; in_tready falls only when both
// entries are full and rises again as the consumer takes a result.
`default_nettype none
module crc8_header_frame_deframer (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] rx_byte
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [55:0]      out_tdata,  // [3:0] frame_length, [35:4] word_at_two,
                                       // [51:36] word_at_six, [55:52] zero
  output logic [2:0]       out_tuser   // [2:0] frame_kind
);
  import cdf_pkg::*;

  logic    byte_en;
  result_t res;
  logic    res_valid;
  result_t out_res;

  assign byte_en = in_tvalid && in_tready;

  cdf_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .byte_in   (in_tdata),
    .res       (res),
    .res_valid (res_valid)
  );

  cdf_skid u_skid (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (res_valid),
    .push_data  (res),
    .push_ready (in_tready),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_data   (out_res)
  );

  assign out_tdata = {4'h0, out_res.word_at_six, out_res.word_at_two, out_res.frame_length};
  assign out_tuser = out_res.frame_kind;

endmodule
`default_nettype wire

/* src/cdf_parser.sv */
// Frame store, byte count and running CRC; detects and checks complete frames.
`default_nettype none
module cdf_parser (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            byte_en,
  input  wire cdf_pkg::byte_t  byte_in,
  output cdf_pkg::result_t     res,
  output logic                 res_valid
);
  import cdf_pkg::*;

  byte_t      store_r [STORE_DEPTH];
  logic [3:0] count_r;
  logic [3:0] count_nxt;
  byte_t      crc_r;
  byte_t      crc_nxt;
  logic [3:0] c_eff;
  byte_t      h1;
  hdr_t       hdr;
  logic       drop;
  logic       done;

  always_comb begin
    c_eff     = (count_r >= 4'(STORE_DEPTH)) ? 4'd0 : count_r;
    h1        = (c_eff == 4'd1) ? byte_in : store_r[1];
    hdr       = header_lookup(store_r[0], h1);
    count_nxt = count_r;
    crc_nxt   = crc_r;
    drop      = 1'b0;
    done      = 1'b0;
    if (byte_en) begin
      priority if (c_eff == 4'd0) begin
        count_nxt = 4'd1;
        crc_nxt   = crc8_step(byte_in);
      end else if (!hdr.known) begin
        drop      = 1'b1;
        count_nxt = 4'd1;
        crc_nxt   = crc8_step(h1);
      end else if ((c_eff + 4'd1) < hdr.len) begin
        count_nxt = c_eff + 4'd1;
        crc_nxt   = crc8_step(crc_r ^ byte_in);
      end else begin
        done      = 1'b1;
        count_nxt = 4'd0;
        crc_nxt   = 8'h00;
      end
    end
    res_valid        = done && (crc_r == byte_in);
    res.frame_kind   = hdr.kind;
    res.frame_length = hdr.len;
    res.word_at_two  = (hdr.len == LEN_ACK) ? {24'h000000, store_r[2]}
                                            : {store_r[5], store_r[4], store_r[3], store_r[2]};
    res.word_at_six  = (hdr.len == LEN_VALUE) ? {store_r[7], store_r[6]} : 16'h0000;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= 4'd0;
      crc_r   <= 8'h00;
    end else begin
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_en) begin
      store_r[c_eff] <= byte_in;
      if (drop) begin
        store_r[0] <= h1;
      end
    end
  end

endmodule
`default_nettype wire

/* src/cdf_skid.sv */
// Output register with a skid stage between the parser and the result channel.
`default_nettype none
module cdf_skid (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire cdf_pkg::result_t  push_data,
  output logic                   push_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output cdf_pkg::result_t       out_data
);
  import cdf_pkg::*;

  logic    out_v_r;
  logic    skid_v_r;
  result_t out_d_r;
  result_t skid_d_r;
  logic    pop;

  assign pop        = out_v_r && out_ready;
  assign push_ready = !skid_v_r;
  assign out_valid  = out_v_r;
  assign out_data   = out_d_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (skid_v_r) begin
      if (pop) begin
        skid_v_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_v_r <= 1'b1;
      end else begin
        skid_v_r <= 1'b1;
      end
    end else if (pop) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_v_r) begin
      if (pop) begin
        out_d_r <= skid_d_r;
      end
    end else if (push) begin
      if (!out_v_r || pop) begin
        out_d_r <= push_data;
      end else begin
        skid_d_r <= push_data;
      end
    end
  end

endmodule
`default_nettype wire
